// File: src/line_follower_pid_defines.svh
// Assertion macros shared by the line follower PID RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LINE_FOLLOWER_PID_DEFINES_SVH
`define LINE_FOLLOWER_PID_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define LFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define LFP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/lfp_pkg.sv
// Types and constants of the line follower PID controller.
// No dependencies; used by the front, back and top-level modules.
package lfp_pkg;

	localparam int SAMPLE_BITS   = 10;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DARK_THRESHOLD    = 3'd0,
		REG_PROPORTIONAL_GAIN = 3'd1,
		REG_DERIVATIVE_GAIN   = 3'd2,
		REG_INTEGRAL_GAIN     = 3'd3,
		REG_BASE_SPEED        = 3'd4,
		REG_SPEED_LIMIT       = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] dark_threshold;
		logic [15:0]            proportional_gain;
		logic [15:0]            derivative_gain;
		logic [15:0]            integral_gain;
		logic [15:0]            base_speed;
		logic [15:0]            speed_limit;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] outer_left_sample;
		logic [SAMPLE_BITS-1:0] inner_left_sample;
		logic [SAMPLE_BITS-1:0] inner_right_sample;
		logic [SAMPLE_BITS-1:0] outer_right_sample;
	} sample_set_t;

	typedef struct packed {
		logic [15:0]        left_speed;
		logic [15:0]        right_speed;
		logic signed [3:0]  line_error;
	} result_t;

	// Classified tick handed from the front to the back.
	typedef struct packed {
		logic signed [3:0]  error;
		logic signed [4:0]  delta;
		logic signed [15:0] integral;
	} work_t;

endpackage

// File: src/lfp_fifo.sv
// Small register-based queue with a combinational head.
// Depends on line_follower_pid_defines.svh for its assertion.
`include "line_follower_pid_defines.svh"

module lfp_fifo #(
	parameter int  DEPTH  = 2,
	parameter type item_t = logic
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  item_t                        wr_data,
	output logic                         full,
	input  logic                         pop,
	output item_t                        rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`LFP_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))

endmodule

// File: src/lfp_front.sv
// Front of the controller: sensor thresholding, pattern to error, error state.
// Depends on lfp_pkg and line_follower_pid_defines.svh.
`include "line_follower_pid_defines.svh"

module lfp_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [lfp_pkg::SAMPLE_BITS-1:0]     dark_threshold,
	input  logic                                take,
	input  lfp_pkg::sample_set_t                samples,
	output lfp_pkg::work_t                      work
);

	localparam logic signed [3:0] ERR_CENTER  = 4'sd0;
	localparam logic signed [3:0] ERR_RIGHT_2 = 4'sd2;
	localparam logic signed [3:0] ERR_RIGHT_3 = 4'sd3;
	localparam logic signed [3:0] ERR_RIGHT_4 = 4'sd4;
	localparam logic signed [3:0] ERR_LEFT_2  = -4'sd2;
	localparam logic signed [3:0] ERR_LEFT_3  = -4'sd3;
	localparam logic signed [3:0] ERR_LEFT_4  = -4'sd4;
	localparam logic signed [16:0] INT_MAX    = 17'sd32767;
	localparam logic signed [16:0] INT_MIN    = -17'sd32767;

	logic [lfp_pkg::SAMPLE_BITS-1:0] smp [4];
	logic [3:0]                      hi;
	logic [3:0]                      lo;
	logic signed [3:0]               held_q;
	logic signed [15:0]              integ_q;
	logic signed [3:0]               err;
	logic signed [16:0]              integ_sum;
	logic signed [15:0]              integ_sat;

	// Index 0 is the outer left sensor, 3 the outer right one.
	assign smp[0] = samples.outer_left_sample;
	assign smp[1] = samples.inner_left_sample;
	assign smp[2] = samples.inner_right_sample;
	assign smp[3] = samples.outer_right_sample;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hi[i] = smp[i] > dark_threshold;
			lo[i] = smp[i] < dark_threshold;
		end
	end

	// A sample equal to the threshold is neither high nor low, so no
	// listed pattern matches and the held error carries over.
	always_comb begin
		err = held_q;
		if (hi[0] && hi[1] && hi[2] && hi[3]) begin
			err = ERR_CENTER;
		end else if (hi[0] && hi[1] && lo[2] && hi[3]) begin
			err = ERR_RIGHT_2;
		end else if (hi[0] && hi[1] && lo[2] && lo[3]) begin
			err = ERR_RIGHT_3;
		end else if (hi[0] && hi[1] && hi[2] && lo[3]) begin
			err = ERR_RIGHT_4;
		end else if (hi[0] && lo[1] && hi[2] && hi[3]) begin
			err = ERR_LEFT_2;
		end else if (lo[0] && lo[1] && hi[2] && hi[3]) begin
			err = ERR_LEFT_3;
		end else if (lo[0] && hi[1] && hi[2] && hi[3]) begin
			err = ERR_LEFT_4;
		end
	end

	always_comb begin
		integ_sum = 17'(integ_q) + 17'(err);
		if (integ_sum > INT_MAX) begin
			integ_sat = 16'(INT_MAX);
		end else if (integ_sum < INT_MIN) begin
			integ_sat = 16'(INT_MIN);
		end else begin
			integ_sat = integ_sum[15:0];
		end
	end

	assign work.error    = err;
	assign work.delta    = 5'(err) - 5'(held_q);
	assign work.integral = integ_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			integ_q <= '0;
		end else if (take) begin
			held_q  <= err;
			integ_q <= integ_sat;
		end
	end

	`LFP_ASSERT_IMPL(a_held_range, clk, arst_n, 1'b1, held_q >= -4'sd4 && held_q <= 4'sd4)
	`LFP_ASSERT_IMPL(a_integ_range, clk, arst_n, 1'b1, integ_q != 16'sh8000)

endmodule

// File: src/lfp_back.sv
// Back of the controller: PID products, sum, wheel speed clamp, result queue.
// Depends on lfp_pkg, lfp_fifo and line_follower_pid_defines.svh.
`include "line_follower_pid_defines.svh"

module lfp_back #(
	parameter int OUT_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lfp_pkg::cfg_t     cfg,
	input  logic              work_empty,
	input  lfp_pkg::work_t    work,
	output logic              work_pop,
	input  logic              pop,
	output logic              empty,
	output lfp_pkg::result_t  result
);

	localparam int OCW = $clog2(OUT_DEPTH + 1);

	logic                     v_s1;
	logic signed [3:0]        err_s1;
	logic signed [20:0]       p_prod_s1;
	logic signed [21:0]       d_prod_s1;
	logic signed [32:0]       i_prod_s1;
	logic                     v_s2;
	logic signed [3:0]        err_s2;
	logic signed [34:0]       pid_s2;
	logic signed [35:0]       left_sum;
	logic signed [35:0]       right_sum;
	logic [OCW-1:0]           out_count;
	logic [OCW:0]             occupancy;
	logic                     out_full;
	lfp_pkg::result_t         out_item;

	function automatic logic [15:0] clamp_speed(logic signed [35:0] v, logic [15:0] lim);
		logic [15:0] r;
		if (v > $signed({20'd0, lim})) begin
			r = lim;
		end else if (v < 36'sd0) begin
			r = '0;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Issue only when the result queue has room for every item in flight,
	// so the two stages never need to stall.
	assign occupancy = (OCW+1)'(out_count) + (OCW+1)'(v_s1) + (OCW+1)'(v_s2);
	assign work_pop  = !work_empty && (occupancy < (OCW+1)'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= work_pop;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		err_s1    <= work.error;
		p_prod_s1 <= $signed({1'b0, cfg.proportional_gain}) * work.error;
		d_prod_s1 <= $signed({1'b0, cfg.derivative_gain}) * work.delta;
		i_prod_s1 <= $signed({1'b0, cfg.integral_gain}) * work.integral;
		err_s2    <= err_s1;
		pid_s2    <= 35'(p_prod_s1) + 35'(d_prod_s1) + 35'(i_prod_s1);
	end

	assign left_sum  = $signed({20'd0, cfg.base_speed}) + 36'(pid_s2);
	assign right_sum = $signed({20'd0, cfg.base_speed}) - 36'(pid_s2);

	assign out_item.left_speed  = clamp_speed(left_sum, cfg.speed_limit);
	assign out_item.right_speed = clamp_speed(right_sum, cfg.speed_limit);
	assign out_item.line_error  = err_s2;

	lfp_fifo #(
		.DEPTH  (OUT_DEPTH),
		.item_t (lfp_pkg::result_t)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (v_s2),
		.wr_data (out_item),
		.full    (out_full),
		.pop     (pop),
		.rd_data (result),
		.empty   (empty),
		.count   (out_count)
	);

	`LFP_ASSERT_IMPL(a_no_out_overflow, clk, arst_n, v_s2, !out_full)
	`LFP_ASSERT_NEXT(a_stage_flow, clk, arst_n, v_s1, v_s2)
	`LFP_ASSERT_IMPL(a_pop_has_item, clk, arst_n, work_pop, !work_empty)

endmodule

// File: src/line_follower_pid.sv
// Top level of the line follower PID controller: registers, front, queue, back.
// Depends on lfp_pkg, lfp_front, lfp_fifo and lfp_back.
//
// Channel    Handshake           Payload
// ---------  ------------------  ---------------------------------------------
// samples    push / full         four reflectance samples of one control tick
// result     empty / pop         left and right wheel speed, line error
// config     cfg_we (no wait)    cfg_index selects the register, cfg_data
//
// One item is taken every cycle while the result side keeps popping. An item
// is classified as it is accepted, then passes through the work queue, the
// multiply stage, the sum stage and the result queue before its result can
// be popped. Reset restores register defaults, clears the error state and
// empties both queues. With pop held low the back stops issuing at OUT_DEPTH
// items in flight, the work queue fills, full rises.

module line_follower_pid #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  lfp_pkg::sample_set_t                  samples,
	output logic                                  empty,
	input  logic                                  pop,
	output lfp_pkg::result_t                      result,
	input  logic                                  cfg_we,
	input  logic [lfp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [lfp_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	lfp_pkg::cfg_t  cfg_q;
	lfp_pkg::work_t front_work;
	lfp_pkg::work_t back_work;
	logic           take;
	logic           mid_empty;
	logic           mid_pop;

	// Register file. Writes must come only while the block is idle; the block
	// itself does not enforce this. The front and back read the current values
	// directly. Unknown indexes fall into the default arm and change nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold    <= lfp_pkg::SAMPLE_BITS'(500);
			cfg_q.proportional_gain <= 16'd256;
			cfg_q.derivative_gain   <= 16'd23;
			cfg_q.integral_gain     <= 16'd0;
			cfg_q.base_speed        <= 16'd1608;
			cfg_q.speed_limit       <= 16'd2560;
		end else if (cfg_we) begin
			case (lfp_pkg::cfg_reg_t'(cfg_index))
				lfp_pkg::REG_DARK_THRESHOLD: begin
					cfg_q.dark_threshold <= cfg_data[lfp_pkg::SAMPLE_BITS-1:0];
				end
				lfp_pkg::REG_PROPORTIONAL_GAIN: begin
					cfg_q.proportional_gain <= cfg_data[15:0];
				end
				lfp_pkg::REG_DERIVATIVE_GAIN: begin
					cfg_q.derivative_gain <= cfg_data[15:0];
				end
				lfp_pkg::REG_INTEGRAL_GAIN: begin
					cfg_q.integral_gain <= cfg_data[15:0];
				end
				lfp_pkg::REG_BASE_SPEED: begin
					cfg_q.base_speed <= cfg_data[15:0];
				end
				lfp_pkg::REG_SPEED_LIMIT: begin
					cfg_q.speed_limit <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The front updates its error state exactly when the item enters the
	// work queue, so full of that queue is the input's full.
	assign take = push && !full;

	lfp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.dark_threshold (cfg_q.dark_threshold),
		.take           (take),
		.samples        (samples),
		.work           (front_work)
	);

	lfp_fifo #(
		.DEPTH  (MID_DEPTH),
		.item_t (lfp_pkg::work_t)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_work),
		.full    (full),
		.pop     (mid_pop),
		.rd_data (back_work),
		.empty   (mid_empty),
		.count   ()
	);

	lfp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.work_empty (mid_empty),
		.work       (back_work),
		.work_pop   (mid_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
